>>> design/derivative_fll_derotator_defines.svh
// ----------------------------------------------------------------------------
// Derivative FLL derotator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DERIVATIVE_FLL_DEROTATOR_DEFINES_SVH
`define DERIVATIVE_FLL_DEROTATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dfd_pkg.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: package
// Widths, register indexes, sequencer states, control struct and sine table.
// ----------------------------------------------------------------------------
package dfd_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int PHASE_WIDTH   = 32;
  localparam int LUT_ADDR_BITS = 10;

  localparam int LUT_SIZE    = 1 << LUT_ADDR_BITS;
  localparam int LUT_QUARTER = LUT_SIZE / 4;
  localparam int ROM_WIDTH   = 16;
  localparam int FRAC_BITS   = 15;
  localparam int ERR_WIDTH   = 34;
  localparam int FREQ_WIDTH  = 32;
  localparam int GAIN_WIDTH  = 16;
  localparam int SHIFT_WIDTH = 6;
  localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 1;

  localparam int MUL_A_WIDTH = (SAMPLE_WIDTH > GAIN_WIDTH) ? SAMPLE_WIDTH : GAIN_WIDTH;
  localparam int MUL_B_WIDTH = (ERR_WIDTH > DIFF_WIDTH) ? ERR_WIDTH : DIFF_WIDTH;
  localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOOP_GAIN  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_SHIFT = 2'd1;

  localparam logic [SHIFT_WIDTH-1:0] GAIN_SHIFT_RESET = 6'd32;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_GAIN = 11'b000_0000_0010,
    ST_M1   = 11'b000_0000_0100,
    ST_M2   = 11'b000_0000_1000,
    ST_M3   = 11'b000_0001_0000,
    ST_M4   = 11'b000_0010_0000,
    ST_M5   = 11'b000_0100_0000,
    ST_M6   = 11'b000_1000_0000,
    ST_M7   = 11'b001_0000_0000,
    ST_M8   = 11'b010_0000_0000,
    ST_OUT  = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic   accept;
    logic   load_out;
    state_t step;
  } ctrl_t;

  typedef logic signed [ROM_WIDTH-1:0] rom_t [LUT_SIZE];

  function automatic logic signed [ROM_WIDTH-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (HALF_PI_Q30 * r) / LUT_QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return ROM_WIDTH'(v);
  endfunction

  function automatic rom_t build_sine_rom();
    rom_t                        rom;
    int                          quad;
    int                          r;
    logic signed [ROM_WIDTH-1:0] v;
    for (int k = 0; k < LUT_SIZE; k++) begin
      quad = k / LUT_QUARTER;
      r    = k % LUT_QUARTER;
      if ((quad & 1) != 0) begin
        v = quarter_sine(64'(LUT_QUARTER - r));
      end else begin
        v = quarter_sine(64'(r));
      end
      rom[k] = ((quad & 2) != 0) ? -v : v;
    end
    return rom;
  endfunction

endpackage

>>> design/dfd_sample_if.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: sample channel
// Valid/ready channel carrying one complex input sample per item.
// ----------------------------------------------------------------------------
interface dfd_sample_if;
  import dfd_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

>>> design/dfd_result_if.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: result channel
// Valid/ready channel carrying the derotated sample and frequency estimate.
// ----------------------------------------------------------------------------
interface dfd_result_if;
  import dfd_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_i;
  logic signed [SAMPLE_WIDTH-1:0] out_q;
  logic signed [FREQ_WIDTH-1:0]   freq_est;

  modport source (output valid, output out_i, output out_q, output freq_est, input ready);
  modport sink (input valid, input out_i, input out_q, input freq_est, output ready);
endinterface

>>> design/dfd_cfg_if.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface dfd_cfg_if;
  import dfd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/dfd_sine_rom.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: sine table
// Constant full-wave sine table with two registered read ports.
// ----------------------------------------------------------------------------
module dfd_sine_rom (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [dfd_pkg::LUT_ADDR_BITS-1:0]          addr_s,
  input  logic [dfd_pkg::LUT_ADDR_BITS-1:0]          addr_c,
  output logic signed [dfd_pkg::ROM_WIDTH-1:0]       sin_val,
  output logic signed [dfd_pkg::ROM_WIDTH-1:0]       cos_val
);
  import dfd_pkg::*;

  localparam rom_t SineRom = build_sine_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= SineRom[addr_s];
      cos_val <= SineRom[addr_c];
    end
  end
endmodule

>>> design/dfd_mult.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: shared multiplier
// Signed multiplier with a registered product, used by every step.
// ----------------------------------------------------------------------------
module dfd_mult (
  input  logic                                     clk,
  input  logic signed [dfd_pkg::MUL_A_WIDTH-1:0]   a,
  input  logic signed [dfd_pkg::MUL_B_WIDTH-1:0]   b,
  output logic signed [dfd_pkg::PROD_WIDTH-1:0]    prod
);
  import dfd_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_WIDTH'(a) * PROD_WIDTH'(b);
  end
endmodule

>>> design/dfd_sequencer.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: sequencer
// Steps one item through the multiply schedule and hands off the result.
// ----------------------------------------------------------------------------
module dfd_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           slot_free,
  output dfd_pkg::ctrl_t ctrl
);
  import dfd_pkg::*;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = ST_M5;
      ST_M5:   state_next = ST_M6;
      ST_M6:   state_next = ST_M7;
      ST_M7:   state_next = ST_M8;
      ST_M8:   state_next = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ctrl.accept   = in_valid && in_ready;
  assign ctrl.load_out = (state == ST_OUT) && slot_free;
  assign ctrl.step     = state;
endmodule

>>> design/dfd_datapath.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: datapath
// Loop state, operand selection for the shared multiplier, accumulation,
// rounding and saturation.
// ----------------------------------------------------------------------------
module dfd_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dfd_pkg::ctrl_t                           ctrl,
  input  logic signed [dfd_pkg::SAMPLE_WIDTH-1:0]  sample_i,
  input  logic signed [dfd_pkg::SAMPLE_WIDTH-1:0]  sample_q,
  input  logic signed [dfd_pkg::GAIN_WIDTH-1:0]    loop_gain,
  input  logic [dfd_pkg::SHIFT_WIDTH-1:0]          gain_shift,
  input  logic signed [dfd_pkg::ROM_WIDTH-1:0]     sin_val,
  input  logic signed [dfd_pkg::ROM_WIDTH-1:0]     cos_val,
  input  logic signed [dfd_pkg::PROD_WIDTH-1:0]    prod,
  output logic signed [dfd_pkg::MUL_A_WIDTH-1:0]   mul_a,
  output logic signed [dfd_pkg::MUL_B_WIDTH-1:0]   mul_b,
  output logic [dfd_pkg::LUT_ADDR_BITS-1:0]        addr_s,
  output logic [dfd_pkg::LUT_ADDR_BITS-1:0]        addr_c,
  output logic signed [dfd_pkg::SAMPLE_WIDTH-1:0]  y_i,
  output logic signed [dfd_pkg::SAMPLE_WIDTH-1:0]  y_q,
  output logic signed [dfd_pkg::FREQ_WIDTH-1:0]    freq_acc
);
  import dfd_pkg::*;

  localparam int PincUp = (PHASE_WIDTH >= FREQ_WIDTH) ? PHASE_WIDTH - FREQ_WIDTH : 0;
  localparam int PincDn = (PHASE_WIDTH < FREQ_WIDTH) ? FREQ_WIDTH - PHASE_WIDTH : 0;
  localparam int PincW  = PHASE_WIDTH + FREQ_WIDTH;

  localparam logic signed [PROD_WIDTH-1:0] RoundHalf = PROD_WIDTH'(1) <<< (FRAC_BITS - 1);

  logic signed [SAMPLE_WIDTH-1:0] xi;
  logic signed [SAMPLE_WIDTH-1:0] xq;
  logic signed [PROD_WIDTH-1:0]   acc;
  logic [PHASE_WIDTH-1:0]         phase_acc;
  logic signed [ERR_WIDTH-1:0]    err_delay;
  logic signed [SAMPLE_WIDTH-1:0] hist_i0;
  logic signed [SAMPLE_WIDTH-1:0] hist_i1;
  logic signed [SAMPLE_WIDTH-1:0] hist_q0;
  logic signed [SAMPLE_WIDTH-1:0] hist_q1;

  logic signed [DIFF_WIDTH-1:0]   diff_i;
  logic signed [DIFF_WIDTH-1:0]   diff_q;
  logic signed [PROD_WIDTH-1:0]   inc;
  logic signed [SUM_WIDTH-1:0]    freq_sum;
  logic signed [FREQ_WIDTH-1:0]   freq_next;
  logic signed [PROD_WIDTH-1:0]   acc_scaled;
  logic signed [SAMPLE_WIDTH-1:0] y_round;
  logic signed [SUM_WIDTH-1:0]    ped;
  logic signed [ERR_WIDTH-1:0]    err_next;
  logic signed [PincW-1:0]        freq_wide;
  logic [PHASE_WIDTH-1:0]         pinc;

  assign addr_s = phase_acc[PHASE_WIDTH-1 -: LUT_ADDR_BITS];
  assign addr_c = addr_s + LUT_ADDR_BITS'(LUT_QUARTER);

  assign diff_i = DIFF_WIDTH'(y_i) - DIFF_WIDTH'(hist_i0);
  assign diff_q = DIFF_WIDTH'(y_q) - DIFF_WIDTH'(hist_q0);

  always_comb begin
    unique case (ctrl.step)
      ST_GAIN: begin
        mul_a = MUL_A_WIDTH'(loop_gain);
        mul_b = MUL_B_WIDTH'(err_delay);
      end
      ST_M1: begin
        mul_a = MUL_A_WIDTH'(xi);
        mul_b = MUL_B_WIDTH'(cos_val);
      end
      ST_M2: begin
        mul_a = MUL_A_WIDTH'(xq);
        mul_b = MUL_B_WIDTH'(sin_val);
      end
      ST_M3: begin
        mul_a = MUL_A_WIDTH'(xq);
        mul_b = MUL_B_WIDTH'(cos_val);
      end
      ST_M4: begin
        mul_a = MUL_A_WIDTH'(xi);
        mul_b = MUL_B_WIDTH'(sin_val);
      end
      ST_M5: begin
        mul_a = MUL_A_WIDTH'(hist_q1);
        mul_b = MUL_B_WIDTH'(diff_i);
      end
      ST_M7: begin
        mul_a = MUL_A_WIDTH'(hist_i1);
        mul_b = MUL_B_WIDTH'(diff_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Floor shift of the gain product, then a saturating integrator.
  assign inc      = prod >>> gain_shift;
  assign freq_sum = SUM_WIDTH'(freq_acc) + SUM_WIDTH'(inc);

  always_comb begin
    if ((&freq_sum[SUM_WIDTH-1:FREQ_WIDTH-1]) || !(|freq_sum[SUM_WIDTH-1:FREQ_WIDTH-1])) begin
      freq_next = freq_sum[FREQ_WIDTH-1:0];
    end else if (freq_sum[SUM_WIDTH-1]) begin
      freq_next = {1'b1, {(FREQ_WIDTH-1){1'b0}}};
    end else begin
      freq_next = {1'b0, {(FREQ_WIDTH-1){1'b1}}};
    end
  end

  assign freq_wide = PincW'(freq_acc);

  always_comb begin
    if (PHASE_WIDTH >= FREQ_WIDTH) begin
      pinc = PHASE_WIDTH'(freq_wide <<< PincUp);
    end else begin
      pinc = PHASE_WIDTH'(freq_wide >>> PincDn);
    end
  end

  // The accumulator already holds the rounding half; shift and saturate.
  assign acc_scaled = acc >>> FRAC_BITS;

  always_comb begin
    if ((&acc_scaled[PROD_WIDTH-1:SAMPLE_WIDTH-1])
        || !(|acc_scaled[PROD_WIDTH-1:SAMPLE_WIDTH-1])) begin
      y_round = acc_scaled[SAMPLE_WIDTH-1:0];
    end else if (acc_scaled[PROD_WIDTH-1]) begin
      y_round = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_round = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  assign ped = SUM_WIDTH'(prod) - SUM_WIDTH'(acc);

  always_comb begin
    if ((&ped[SUM_WIDTH-1:ERR_WIDTH-1]) || !(|ped[SUM_WIDTH-1:ERR_WIDTH-1])) begin
      err_next = ped[ERR_WIDTH-1:0];
    end else if (ped[SUM_WIDTH-1]) begin
      err_next = {1'b1, {(ERR_WIDTH-1){1'b0}}};
    end else begin
      err_next = {1'b0, {(ERR_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      freq_acc  <= '0;
      err_delay <= '0;
      hist_i0   <= '0;
      hist_i1   <= '0;
      hist_q0   <= '0;
      hist_q1   <= '0;
    end else begin
      if (ctrl.step == ST_M1) begin
        freq_acc <= freq_next;
      end
      if (ctrl.step == ST_M2) begin
        phase_acc <= phase_acc + pinc;
      end
      if (ctrl.step == ST_M8) begin
        err_delay <= err_next;
        hist_i0   <= hist_i1;
        hist_q0   <= hist_q1;
        hist_i1   <= y_i;
        hist_q1   <= y_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      xi <= sample_i;
      xq <= sample_q;
    end
    unique case (ctrl.step)
      ST_M2: acc <= prod + RoundHalf;
      ST_M3: acc <= acc + prod;
      ST_M4: begin
        y_i <= y_round;
        acc <= prod + RoundHalf;
      end
      ST_M5: acc <= acc - prod;
      ST_M6: begin
        y_q <= y_round;
        acc <= prod;
      end
      default: acc <= acc;
    endcase
  end
endmodule

>>> design/derivative_fll_derotator.sv
// An accepted sample item runs the nine-step schedule (GAIN, M1 to M8) on the
// single shared multiplier, then waits in OUT for a free result slot, so a
// result that is not yet taken delays the next; new items wait for that hand-off.
// Reset: synchronous, active high; clears phase, frequency, delayed error and
// sample history, sets loop_gain to 0 and gain_shift to 32.
// ----------------------------------------------------------------------------
// Derivative FLL derotator: top level
// Cross-product frequency locked loop with a derotating oscillator.
// ----------------------------------------------------------------------------
`include "derivative_fll_derotator_defines.svh"

module derivative_fll_derotator (
  input  logic          clk,
  input  logic          rst,
  dfd_sample_if.sink    samples,
  dfd_result_if.source  results,
  dfd_cfg_if.sink       cfg
);
  import dfd_pkg::*;

  logic signed [GAIN_WIDTH-1:0]   loop_gain;
  logic [SHIFT_WIDTH-1:0]         gain_shift;
  ctrl_t                          ctrl;
  logic                           slot_free;
  logic signed [MUL_A_WIDTH-1:0]  mul_a;
  logic signed [MUL_B_WIDTH-1:0]  mul_b;
  logic signed [PROD_WIDTH-1:0]   prod;
  logic [LUT_ADDR_BITS-1:0]       addr_s;
  logic [LUT_ADDR_BITS-1:0]       addr_c;
  logic signed [ROM_WIDTH-1:0]    sin_val;
  logic signed [ROM_WIDTH-1:0]    cos_val;
  logic signed [SAMPLE_WIDTH-1:0] y_i;
  logic signed [SAMPLE_WIDTH-1:0] y_q;
  logic signed [FREQ_WIDTH-1:0]   freq_acc;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_gain  <= '0;
      gain_shift <= GAIN_SHIFT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LOOP_GAIN:  loop_gain  <= cfg.data[GAIN_WIDTH-1:0];
        REG_GAIN_SHIFT: gain_shift <= cfg.data[SHIFT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  assign slot_free = !results.valid || results.ready;

  dfd_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .slot_free (slot_free),
    .ctrl      (ctrl)
  );

  dfd_sine_rom u_rom (
    .clk     (clk),
    .en      (ctrl.accept),
    .addr_s  (addr_s),
    .addr_c  (addr_c),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  dfd_mult u_mult (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  dfd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample_i   (samples.sample_i),
    .sample_q   (samples.sample_q),
    .loop_gain  (loop_gain),
    .gain_shift (gain_shift),
    .sin_val    (sin_val),
    .cos_val    (cos_val),
    .prod       (prod),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .addr_s     (addr_s),
    .addr_c     (addr_c),
    .y_i        (y_i),
    .y_q        (y_q),
    .freq_acc   (freq_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ctrl.load_out) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      results.out_i    <= y_i;
      results.out_q    <= y_q;
      results.freq_est <= freq_acc;
    end
  end

  `DFD_ASSERT_NEXT(a_busy_after_accept, samples.valid && samples.ready, !samples.ready,
    "sample channel still ready in the cycle after an item was accepted")
  `DFD_ASSERT_SAME(a_load_into_free_slot, ctrl.load_out, slot_free,
    "result loaded while the output register still held an untaken item")
  `DFD_ASSERT_NEXT(a_idle_after_load, ctrl.load_out, samples.ready,
    "sequencer not idle after handing off a result")
  `DFD_ASSERT_SAME(a_valid_from_load, $rose(results.valid), $past(ctrl.load_out),
    "result valid rose without a load from the sequencer")
endmodule

>>> verif/derivative_fll_derotator_tb.sv
// ----------------------------------------------------------------------------
// Derivative FLL derotator: testbench
// Sends complex sample items through the derotator and checks each derotated
// sample and frequency estimate against a cycle-free model of the loop, kept
// in a scoreboard, under random idling on both channels and several loop
// settings, including the gain and shift extremes.
// ----------------------------------------------------------------------------
module derivative_fll_derotator_tb;
  import dfd_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS = 107;

  class fll_scoreboard;
    localparam longint FREQ_MAX = 64'sd2147483647;
    localparam longint FREQ_MIN = -64'sd2147483648;
    localparam longint ERR_MAX = (64'sd1 <<< (ERR_WIDTH - 1)) - 64'sd1;
    localparam longint ERR_MIN = -(64'sd1 <<< (ERR_WIDTH - 1));

    typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] out_i;
      logic signed [SAMPLE_WIDTH-1:0] out_q;
      logic signed [FREQ_WIDTH-1:0]   freq_est;
    } result_t;

    int                             sine_tab [LUT_SIZE];
    logic [PHASE_WIDTH-1:0]         phase_acc;
    logic signed [FREQ_WIDTH-1:0]   freq_acc;
    logic signed [ERR_WIDTH-1:0]    err_delay;
    logic signed [SAMPLE_WIDTH-1:0] hist_i [2];
    logic signed [SAMPLE_WIDTH-1:0] hist_q [2];
    logic signed [GAIN_WIDTH-1:0]   loop_gain;
    logic [SHIFT_WIDTH-1:0]         gain_shift;
    result_t                        expected_outputs [$];
    int unsigned                    fault_count;

    // The sine table is built from a quarter wave by a truncated Taylor series.
    function new();
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned term;
      longint          sum;
      int unsigned     quad;
      int unsigned     r;
      int              mag;
      for (int k = 0; k < LUT_SIZE; k++) begin
        quad = k / LUT_QUARTER;
        r    = k % LUT_QUARTER;
        if (quad[0]) begin
          r = LUT_QUARTER - r;
        end
        ang  = HALF_PI_Q30 * r / LUT_QUARTER;
        ang2 = (ang * ang) >> 30;
        term = ang;
        sum  = longint'(ang);
        for (int n = 1; n <= 7; n++) begin
          term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        sum = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
        mag = (sum > 64'sd32767) ? 32767 : int'(sum);
        sine_tab[k] = quad[1] ? -mag : mag;
      end
      phase_acc   = '0;
      freq_acc    = '0;
      err_delay   = '0;
      hist_i      = '{default: '0};
      hist_q      = '{default: '0};
      loop_gain   = '0;
      gain_shift  = GAIN_SHIFT_RESET;
      fault_count = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] index,
                            logic [CFG_DATA_WIDTH-1:0] data);
      case (index)
        REG_LOOP_GAIN: begin
          loop_gain = data;
        end
        REG_GAIN_SHIFT: begin
          gain_shift = data[SHIFT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic signed [SAMPLE_WIDTH-1:0] round_to_sample(longint acc);
      longint t;
      t = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (t > 64'sd32767) begin
        t = 64'sd32767;
      end else if (t < -64'sd32768) begin
        t = -64'sd32768;
      end
      return SAMPLE_WIDTH'(t);
    endfunction

    // Derotates one sample and advances the loop by one item.
    function void note_sample(logic signed [SAMPLE_WIDTH-1:0] si,
                              logic signed [SAMPLE_WIDTH-1:0] sq);
      logic [LUT_ADDR_BITS-1:0]       sin_addr;
      logic [LUT_ADDR_BITS-1:0]       cos_addr;
      longint                         s;
      longint                         c;
      longint                         ped;
      longint                         inc;
      longint                         fsum;
      logic signed [SAMPLE_WIDTH-1:0] yi;
      logic signed [SAMPLE_WIDTH-1:0] yq;
      result_t                        res;
      sin_addr = phase_acc[PHASE_WIDTH-1 -: LUT_ADDR_BITS];
      cos_addr = sin_addr + LUT_ADDR_BITS'(LUT_QUARTER);
      s  = sine_tab[sin_addr];
      c  = sine_tab[cos_addr];
      yi = round_to_sample(longint'(si) * c + longint'(sq) * s);
      yq = round_to_sample(longint'(sq) * c - longint'(si) * s);
      ped = longint'(hist_i[1]) * (longint'(yq) - longint'(hist_q[0]))
          - longint'(hist_q[1]) * (longint'(yi) - longint'(hist_i[0]));
      inc  = (longint'(loop_gain) * longint'(err_delay)) >>> gain_shift;
      fsum = longint'(freq_acc) + inc;
      if (fsum > FREQ_MAX) begin
        fsum = FREQ_MAX;
      end else if (fsum < FREQ_MIN) begin
        fsum = FREQ_MIN;
      end
      freq_acc  = FREQ_WIDTH'(fsum);
      phase_acc = phase_acc + freq_acc;
      if (ped > ERR_MAX) begin
        ped = ERR_MAX;
      end else if (ped < ERR_MIN) begin
        ped = ERR_MIN;
      end
      err_delay = ERR_WIDTH'(ped);
      hist_i[0] = hist_i[1];
      hist_q[0] = hist_q[1];
      hist_i[1] = yi;
      hist_q[1] = yq;
      res.out_i    = yi;
      res.out_q    = yq;
      res.freq_est = freq_acc;
      expected_outputs.push_back(res);
    endfunction

    function void check_result(logic signed [SAMPLE_WIDTH-1:0] oi,
                               logic signed [SAMPLE_WIDTH-1:0] oq,
                               logic signed [FREQ_WIDTH-1:0] fe);
      result_t want;
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected result item out_i %0d out_q %0d freq_est %0d",
                 $time, oi, oq, fe);
        fault_count++;
        return;
      end
      want = expected_outputs.pop_front();
      if (oi !== want.out_i) begin
        $display("%0t: out_i expected %0d, got %0d", $time, want.out_i, oi);
        fault_count++;
      end
      if (oq !== want.out_q) begin
        $display("%0t: out_q expected %0d, got %0d", $time, want.out_q, oq);
        fault_count++;
      end
      if (fe !== want.freq_est) begin
        $display("%0t: freq_est expected %0d, got %0d", $time, want.freq_est, fe);
        fault_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = 0;
  bit   long_hold = 1'b0;
  int unsigned quiet_cycles = 0;

  fll_scoreboard sb = new();

  dfd_sample_if samples_ch ();
  dfd_result_if results_ch ();
  dfd_cfg_if    cfg_ch ();

  derivative_fll_derotator dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] si,
                             input logic signed [SAMPLE_WIDTH-1:0] sq);
    samples_ch.valid    <= 1'b1;
    samples_ch.sample_i <= si;
    samples_ch.sample_q <= sq;
    do @(posedge clk); while (!samples_ch.ready);
    sb.note_sample(si, sq);
  endtask

  task automatic sender_gap();
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      samples_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain();
    samples_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_outputs.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(index, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    results_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 199) < idle_pct) begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        results_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      sb.check_result(results_ch.out_i, results_ch.out_q, results_ch.freq_est);
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) ||
        (results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("derivative_fll_derotator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [SAMPLE_WIDTH-1:0] corner_i [8];
    logic signed [SAMPLE_WIDTH-1:0] corner_q [8];
    logic signed [SAMPLE_WIDTH-1:0] si;
    logic signed [SAMPLE_WIDTH-1:0] sq;
    logic [CFG_DATA_WIDTH-1:0]      gain;
    logic [CFG_DATA_WIDTH-1:0]      shift_word;
    bit                             noise;
    int                             seg_left;
    int                             amp;
    int                             ph;
    int                             step;

    samples_ch.valid    = 1'b0;
    samples_ch.sample_i = '0;
    samples_ch.sample_q = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    corner_i = '{16'sd0, 16'sd32767, 16'sd0, 16'sh8000,
                 16'sd32767, 16'sh8000, 16'sd32767, 16'shffff};
    corner_q = '{16'sd0, 16'sd0, 16'sd32767, 16'sh8000,
                 16'sd32767, 16'sd32767, 16'sh8000, 16'shffff};
    seg_left = 0;
    noise    = 1'b0;
    amp      = 0;
    ph       = 0;
    step     = 0;
    idle_pct = 20;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Start-up with reset settings: history and delayed error are still zero.
    for (int k = 0; k < 8; k++) begin
      sender_gap();
      send_sample(corner_i[k], corner_q[k]);
    end

    // Largest gain with no shift in both signs drives the integrator into
    // its limits.
    drain();
    write_reg(REG_LOOP_GAIN, 16'h7fff);
    write_reg(REG_GAIN_SHIFT, 16'd0);
    for (int k = 3; k < 8; k++) begin
      sender_gap();
      send_sample(corner_i[k], corner_q[k]);
    end
    drain();
    write_reg(REG_LOOP_GAIN, 16'h8000);
    for (int k = 3; k < 8; k++) begin
      sender_gap();
      send_sample(corner_i[k], corner_q[k]);
    end

    // The widest shift leaves an increment of zero or minus one.
    drain();
    write_reg(REG_LOOP_GAIN, 16'd1234);
    write_reg(REG_GAIN_SHIFT, 16'hffff);
    for (int k = 1; k < 4; k++) begin
      sender_gap();
      send_sample(corner_i[k], corner_q[k]);
    end

    // Writes to unused register indexes must change nothing.
    drain();
    write_reg(REG_SPARE_A, 16'hffff);
    write_reg(REG_SPARE_B, 16'h5a5a);
    for (int k = 4; k < 6; k++) begin
      sender_gap();
      send_sample(corner_i[k], corner_q[k]);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      if (p == 0) begin
        gain  = 16'd12000;
        shift_word = 16'd30;
      end else begin
        case ($urandom_range(0, 3))
          0: gain = 16'h8000;
          1: gain = 16'h7fff;
          2: gain = 16'($urandom);
          default: gain = 16'($urandom_range(500, 20000));
        endcase
        shift_word = 16'($urandom);
        case ($urandom_range(0, 3))
          0: shift_word[SHIFT_WIDTH-1:0] = 6'd0;
          1: shift_word[SHIFT_WIDTH-1:0] = 6'd63;
          default: shift_word[SHIFT_WIDTH-1:0] = 6'($urandom_range(24, 44));
        endcase
      end
      write_reg(REG_LOOP_GAIN, gain);
      write_reg(REG_GAIN_SHIFT, shift_word);
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
      end
      if (p == RANDOM_PHASES - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 10;
          2: idle_pct = 25;
          default: idle_pct = 45;
        endcase
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) begin
          long_hold = 1'b1;
        end
        if (p == 3 && n == 50) begin
          drain();
        end
        if (seg_left == 0) begin
          noise    = ($urandom_range(0, 3) == 0);
          seg_left = $urandom_range(8, 60);
          amp      = $urandom_range(1, 32767);
          ph       = $urandom_range(0, LUT_SIZE - 1);
          step     = int'($urandom_range(0, 80)) - 40;
        end
        if (noise) begin
          si = SAMPLE_WIDTH'($urandom);
          sq = SAMPLE_WIDTH'($urandom);
          if ($urandom_range(0, 7) == 0) begin
            si = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
          end
        end else begin
          si = SAMPLE_WIDTH'((amp * sb.sine_tab[(ph + LUT_QUARTER) % LUT_SIZE]) >>> 15);
          sq = SAMPLE_WIDTH'((amp * sb.sine_tab[ph]) >>> 15);
          ph = (ph + step + LUT_SIZE) % LUT_SIZE;
        end
        seg_left--;
        sender_gap();
        send_sample(si, sq);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fault_count == 0 && sb.expected_outputs.size() == 0) begin
      $display("derivative_fll_derotator: match");
    end else begin
      $display("derivative_fll_derotator: mismatch");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/dfd_pkg.sv
design/dfd_sample_if.sv
design/dfd_result_if.sv
design/dfd_cfg_if.sv
design/dfd_sine_rom.sv
design/dfd_mult.sv
design/dfd_sequencer.sv
design/dfd_datapath.sv
design/derivative_fll_derotator.sv
verif/derivative_fll_derotator_tb.sv
